/* rtl/swm_pkg.sv */
// Shared constants and types for the sliding window median filter.
package swm_pkg;

    // Default sizes
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Window size register
    localparam int                 WSIZE_WIDTH = 7;
    localparam logic [WSIZE_WIDTH-1:0] WSIZE_RESET = 7'd3;

    // Per-cycle command broadcast to every cell of the sorted chain
    typedef struct packed {
        logic flush;   // window emptied before this word enters
        logic evict;   // drop the oldest live sample
        logic insert;  // put the incoming sample in order
    } swm_ctrl_t;

endpackage

/* rtl/sliding_window_median.sv */
// Sliding window median filter: sorted chain of cells and handshake control.
//
// Input channel: sample, restart with sample_valid / sample_stall. A word is
// taken at a clock edge where sample_valid is high and sample_stall is low.
// restart empties the window; that word starts a new sequence.
// Output channel: median_times_two with result_valid / result_stall. Once
// window_size words are held, each word yields the sum of the two middle
// values of the sorted window (twice the median). window_size is written
// through window_size_we / window_size_wdata; the user writes it only while
// the filter is idle (the block does not enforce it); 0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX. Latency: result_valid rises at the edge after
// its word is taken, unless a stalled result still occupies the output register.
// Throughput: one word per cycle while no result waits for the output register.
// After a shrink, the input stalls while the window holds more samples than
// window_size, since the chain drops one oldest sample per cycle.
// Each cell compares its sample with the incoming one and shifts by one
// place; the median sum is read from the updated chain when the output frees.
// Reset: the window is empty and window_size is 3.
// A stalled result holds in the output register; a second pending result
// stalls the input until the output register frees.
module sliding_window_median #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   window_size_we,
    input  logic [swm_pkg::WSIZE_WIDTH-1:0]        window_size_wdata,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample,
    input  logic                                   restart,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [SAMPLE_WIDTH:0]           median_times_two
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (KW > swm_pkg::WSIZE_WIDTH) ? KW : swm_pkg::WSIZE_WIDTH;

    logic [swm_pkg::WSIZE_WIDTH-1:0] wsize_reg;
    logic [KW-1:0]                   fill_reg, fill_next;
    logic                            pend_reg, pend_next;
    logic                            out_valid_reg;
    logic signed [SAMPLE_WIDTH:0]    out_data_reg;

    logic [CW-1:0]                   wsize_ext;
    logic [KW-1:0]                   k_eff;
    logic [KW-1:0]                   fill_eff;
    logic [KW-1:0]                   oldest_full;
    logic [AW-1:0]                   oldest_age;
    logic                            hold;
    logic                            need_shrink;
    logic                            accept;
    logic                            shrink_go;
    logic                            full_now;
    logic                            load_out;
    logic signed [SAMPLE_WIDTH:0]    mid_sum;
    swm_pkg::swm_ctrl_t              ctrl;

    logic signed [SAMPLE_WIDTH-1:0]  cell_value [WINDOW_MAX];
    logic        [AW-1:0]            cell_age   [WINDOW_MAX];
    logic        [WINDOW_MAX-1:0]    cell_valid;
    logic        [WINDOW_MAX-1:0]    cell_gt;
    logic signed [SAMPLE_WIDTH-1:0]  sh_value   [WINDOW_MAX];
    logic        [AW-1:0]            sh_age     [WINDOW_MAX];
    logic        [WINDOW_MAX-1:0]    sh_valid;
    logic        [WINDOW_MAX-1:0]    sh_gt;
    logic        [WINDOW_MAX-1:0]    rb;

    // Window size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg <= swm_pkg::WSIZE_RESET;
        end
        else if (window_size_we)
        begin
            wsize_reg <= window_size_wdata;
        end
    end

    // Effective window length, clamped to 1..WINDOW_MAX
    assign wsize_ext = CW'(wsize_reg);
    always_comb
    begin
        if (wsize_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (wsize_ext > CW'(WINDOW_MAX))
        begin
            k_eff = KW'(WINDOW_MAX);
        end
        else
        begin
            k_eff = wsize_ext[KW-1:0];
        end
    end

    // Handshake and chain command
    assign load_out    = pend_reg & ~(out_valid_reg & result_stall);
    assign hold        = pend_reg & ~load_out;
    assign need_shrink = ~restart & (fill_reg > k_eff);
    assign sample_stall = hold | need_shrink;
    assign accept      = sample_valid & ~sample_stall;
    assign shrink_go   = sample_valid & ~hold & need_shrink;
    assign fill_eff    = restart ? '0 : fill_reg;
    assign full_now    = (fill_eff == k_eff);

    assign ctrl.flush  = accept & restart;
    assign ctrl.insert = accept;
    assign ctrl.evict  = shrink_go | (accept & full_now);

    assign oldest_full = fill_reg - KW'(1);
    assign oldest_age  = oldest_full[AW-1:0];

    // Fill count and pending result
    always_comb
    begin
        fill_next = fill_reg;
        pend_next = pend_reg;
        if (load_out)
        begin
            pend_next = 1'b0;
        end
        if (shrink_go)
        begin
            fill_next = fill_reg - KW'(1);
        end
        else if (accept)
        begin
            fill_next = full_now ? fill_eff : fill_eff + KW'(1);
            pend_next = full_now | ((fill_eff + KW'(1)) == k_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

    // Sorted chain
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            logic signed [SAMPLE_WIDTH-1:0] up_value;
            logic        [AW-1:0]           up_age;
            logic                           up_valid;
            logic                           up_gt;
            logic signed [SAMPLE_WIDTH-1:0] lo_value;
            logic        [AW-1:0]           lo_age;
            logic                           lo_valid;
            logic                           lo_gt;
            logic                           rb_in;

            if (gi == WINDOW_MAX - 1)
            begin : g_top
                assign up_value = '0;
                assign up_age   = '0;
                assign up_valid = 1'b0;
                assign up_gt    = 1'b1;
            end
            else
            begin : g_mid
                assign up_value = cell_value[gi+1];
                assign up_age   = cell_age[gi+1];
                assign up_valid = cell_valid[gi+1];
                assign up_gt    = cell_gt[gi+1];
            end

            if (gi == 0)
            begin : g_bot
                assign lo_value = '0;
                assign lo_age   = '0;
                assign lo_valid = 1'b1;
                assign lo_gt    = 1'b0;
                assign rb_in    = 1'b0;
            end
            else
            begin : g_low
                assign lo_value = sh_value[gi-1];
                assign lo_age   = sh_age[gi-1];
                assign lo_valid = sh_valid[gi-1];
                assign lo_gt    = sh_gt[gi-1];
                assign rb_in    = rb[gi-1];
            end

            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .AGE_WIDTH    (AW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sample     (sample),
                .oldest_age (oldest_age),
                .up_value   (up_value),
                .up_age     (up_age),
                .up_valid   (up_valid),
                .up_gt      (up_gt),
                .lo_value   (lo_value),
                .lo_age     (lo_age),
                .lo_valid   (lo_valid),
                .lo_gt      (lo_gt),
                .rb_in      (rb_in),
                .value      (cell_value[gi]),
                .age        (cell_age[gi]),
                .valid      (cell_valid[gi]),
                .gt         (cell_gt[gi]),
                .sh_value   (sh_value[gi]),
                .sh_age     (sh_age[gi]),
                .sh_valid   (sh_valid[gi]),
                .sh_gt      (sh_gt[gi]),
                .rb_out     (rb[gi])
            );
        end
    endgenerate

    // Median pick from the settled chain
    swm_median #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .KW           (KW)
    ) u_median (
        .cell_value (cell_value),
        .k          (k_eff),
        .sum        (mid_sum)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= mid_sum;
        end
    end

    assign result_valid     = out_valid_reg;
    assign median_times_two = out_data_reg;

    // Live cells form a contiguous run whose length is the fill count
    a_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == fill_reg)
        else $error("cell valid count differs from fill count");

    // Chain frozen while a result waits for the output register
    a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> $stable(cell_valid) && $stable(fill_reg))
        else $error("chain changed while a result was pending");

    // Every new result comes from a pending pick
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pend_reg))
        else $error("result appeared without a pending pick");

endmodule

/* rtl/swm_cell.sv */
// One cell of the sorted chain: holds a sample, its age and a valid flag.
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int AGE_WIDTH    = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_pkg::swm_ctrl_t             ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic        [AGE_WIDTH-1:0]    oldest_age,
    // raw view of the cell above
    input  logic signed [SAMPLE_WIDTH-1:0] up_value,
    input  logic        [AGE_WIDTH-1:0]    up_age,
    input  logic                           up_valid,
    input  logic                           up_gt,
    // post-eviction view of the cell below
    input  logic signed [SAMPLE_WIDTH-1:0] lo_value,
    input  logic        [AGE_WIDTH-1:0]    lo_age,
    input  logic                           lo_valid,
    input  logic                           lo_gt,
    input  logic                           rb_in,
    // raw view of this cell
    output logic signed [SAMPLE_WIDTH-1:0] value,
    output logic        [AGE_WIDTH-1:0]    age,
    output logic                           valid,
    output logic                           gt,
    // post-eviction view of this cell
    output logic signed [SAMPLE_WIDTH-1:0] sh_value,
    output logic        [AGE_WIDTH-1:0]    sh_age,
    output logic                           sh_valid,
    output logic                           sh_gt,
    output logic                           rb_out
);

    logic signed [SAMPLE_WIDTH-1:0] value_reg, value_next;
    logic        [AGE_WIDTH-1:0]    age_reg, age_next;
    logic                           valid_reg, valid_next;
    logic                           live;
    logic                           up_live;
    logic                           hit;
    logic                           rb;

    // Live view: a flush empties the whole window
    assign live    = valid_reg & ~ctrl.flush;
    assign up_live = up_valid & ~ctrl.flush;
    // Empty cells count as larger than any sample
    assign gt      = ~live | (value_reg > sample);

    // Eviction: this cell holds the oldest sample
    assign hit    = ctrl.evict & live & (age_reg == oldest_age);
    assign rb     = rb_in | hit;
    assign rb_out = rb;

    // Cells at or above the evicted one close the gap from above
    assign sh_value = rb ? up_value : value_reg;
    assign sh_age   = rb ? up_age   : age_reg;
    assign sh_valid = rb ? up_live  : live;
    assign sh_gt    = rb ? up_gt    : gt;

    // Insertion after eviction
    always_comb
    begin
        value_next = sh_value;
        age_next   = sh_age;
        valid_next = sh_valid;
        if (ctrl.insert)
        begin
            valid_next = sh_valid | lo_valid;
            if (!sh_gt)
            begin
                age_next = sh_age + AGE_WIDTH'(1);
            end
            else if (lo_gt)
            begin
                value_next = lo_value;
                age_next   = lo_age + AGE_WIDTH'(1);
            end
            else
            begin
                value_next = sample;
                age_next   = '0;
            end
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.insert || ctrl.evict)
        begin
            valid_reg <= valid_next;
        end
    end

    // Sample and age payload
    always_ff @(posedge clk)
    begin
        if (ctrl.insert || ctrl.evict)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;
    assign valid = valid_reg;

endmodule

/* rtl/swm_median.sv */
// Picks the two middle cells of the sorted chain and adds them.
module swm_median #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int KW           = 7
) (
    input  logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX],
    input  logic        [KW-1:0]           k,
    output logic signed [SAMPLE_WIDTH:0]   sum
);

    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [KW-1:0]                  lo_full;
    logic [KW-1:0]                  hi_full;
    logic [IW-1:0]                  lo_idx;
    logic [IW-1:0]                  hi_idx;
    logic signed [SAMPLE_WIDTH-1:0] lo_val;
    logic signed [SAMPLE_WIDTH-1:0] hi_val;

    // Middle positions: (k-1)/2 and k/2
    assign lo_full = (k - KW'(1)) >> 1;
    assign hi_full = k >> 1;
    assign lo_idx  = lo_full[IW-1:0];
    assign hi_idx  = hi_full[IW-1:0];

    assign lo_val = cell_value[lo_idx];
    assign hi_val = cell_value[hi_idx];

    // Exact sum, one bit wider than a sample
    assign sum = (SAMPLE_WIDTH+1)'(lo_val) + (SAMPLE_WIDTH+1)'(hi_val);

endmodule

/* tb/tb_sliding_window_median.sv */
// Self-checking testbench for the sliding window median filter.
module tb_sliding_window_median;

    localparam int SAMPLE_W   = swm_pkg::SAMPLE_WIDTH_DEF;
    localparam int WIN_MAX    = swm_pkg::WINDOW_MAX_DEF;
    localparam int WSIZE_W    = swm_pkg::WSIZE_WIDTH;
    localparam int STALL_LIMIT = 4000;
    localparam int N_PHASES   = 12;
    localparam int PHASE_WORDS = 86;
    localparam int N_DIRECTED = 22;

    typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        row_kind_t                 kind;
        logic [SAMPLE_W-1:0]       value;     // sample, or window size for ROW_WINDOW
        bit                        restart;
        bit                        has_typed; // median typed in below
        logic signed [SAMPLE_W:0]  typed;
    } dir_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          window_size_we = 1'b0;
    logic [WSIZE_W-1:0]            window_size_wdata = '0;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    logic signed [SAMPLE_W-1:0]    sample = '0;
    logic                          restart = 1'b0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic signed [SAMPLE_W:0]      median_times_two;

    // Predictor state: arrival ring, sorted window, fill and write pointer
    logic signed [SAMPLE_W-1:0]    win_ring [WIN_MAX];
    logic signed [SAMPLE_W-1:0]    win_sorted [WIN_MAX];
    int                            win_fill;
    int                            win_ptr;
    logic [WSIZE_W-1:0]            win_size;

    logic signed [SAMPLE_W:0]      pending_medians [$];
    dir_row_t                      dir_rows [N_DIRECTED];
    int                            send_idle_pct = 0;
    int                            recv_stall_pct = 0;
    int                            err_count = 0;
    int                            words_sent = 0;
    int                            medians_checked = 0;
    int                            restarts_sent = 0;
    int                            window_writes = 0;
    int                            quiet_cycles = 0;

    sliding_window_median u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .window_size_we    (window_size_we),
        .window_size_wdata (window_size_wdata),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .sample            (sample),
        .restart           (restart),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .median_times_two  (median_times_two)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Window length in effect: 0 acts as 1, anything above the maximum saturates
    function automatic int eff_window();
        int k;
        k = win_size;
        if (k == 0)
            k = 1;
        if (k > WIN_MAX)
            k = WIN_MAX;
        return k;
    endfunction

    // Advance the predicted window by one word; gives twice the median if full
    function automatic void update_window(input logic signed [SAMPLE_W-1:0] s,
                                          input bit new_seq, output bit full,
                                          output logic signed [SAMPLE_W:0] med2);
        int k;
        int oldest;
        int i;
        int pos;
        logic signed [SAMPLE_W:0] lo;
        logic signed [SAMPLE_W:0] hi;
        k = eff_window();
        if (new_seq)
        begin
            win_fill = 0;
            win_ptr = 0;
        end
        // drop oldest samples until there is room; one copy of a duplicate only
        while (win_fill >= k)
        begin
            oldest = (win_ptr + WIN_MAX - win_fill) % WIN_MAX;
            i = 0;
            while (i < win_fill && win_sorted[i] != win_ring[oldest])
                i++;
            for (; i + 1 < win_fill; i++)
                win_sorted[i] = win_sorted[i + 1];
            win_fill--;
        end
        // ordered insert, after any equal values
        pos = 0;
        while (pos < win_fill && win_sorted[pos] <= s)
            pos++;
        for (i = win_fill; i > pos; i--)
            win_sorted[i] = win_sorted[i - 1];
        win_sorted[pos] = s;
        win_ring[win_ptr] = s;
        win_ptr = (win_ptr + 1) % WIN_MAX;
        win_fill++;
        full = (win_fill == k);
        lo = win_sorted[(k - 1) / 2];
        hi = win_sorted[k / 2];
        med2 = lo + hi;
    endfunction

    // Drive one word, with random gaps before it; record the predicted median
    task automatic send_word(input logic [SAMPLE_W-1:0] s, input bit r, input bit has_typed,
                             input logic signed [SAMPLE_W:0] typed);
        bit full;
        logic signed [SAMPLE_W:0] med2;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        restart <= r;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        update_window(s, r, full, med2);
        if (full)
            pending_medians = {pending_medians, (has_typed ? typed : med2)};
        words_sent++;
        if (r)
            restarts_sent++;
        @(negedge clk);
    endtask

    // Hold the sender until every pending median has come out
    task automatic wait_drain();
        sample_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Window size write, only with the filter idle
    task automatic write_window(input logic [WSIZE_W-1:0] v);
        wait_drain();
        repeat (6) @(negedge clk);
        window_size_we <= 1'b1;
        window_size_wdata <= v;
        @(negedge clk);
        window_size_we <= 1'b0;
        win_size = v;
        window_writes++;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct = 56;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 56;
            end
            default:
            begin
                send_idle_pct = 30;
                recv_stall_pct = 30;
            end
        endcase
    endtask

    // Mix of full-range values, narrow values that repeat, and extremes
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            5, 6, 7: return SAMPLE_W'($urandom_range(15)) - SAMPLE_W'(8);
            8: case ($urandom_range(3))
                   0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
                   1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
                   2: return '0;
                   default: return '1;
               endcase
            9: return {1'($urandom_range(1)), {(SAMPLE_W-5){1'(~$urandom_range(1))}},
                       4'($urandom)};
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Receiver stall, changed on the falling edge
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_stall_pct);

    // Compare every accepted result with the oldest pending median
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W:0] want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_medians.size() == 0)
                report_mismatch($sformatf("unexpected median %0d", median_times_two));
            else
            begin
                want = pending_medians.pop_front();
                if (median_times_two !== want)
                    report_mismatch($sformatf("median_times_two %0d, want %0d",
                                              median_times_two, want));
                medians_checked++;
            end
        end
    end

    // Watchdog: cycles without any word moving on either side
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no word moved in %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [WSIZE_W-1:0] phase_sizes [N_PHASES];
        int restart_odds;

        win_fill = 0;
        win_ptr = 0;
        win_size = swm_pkg::WSIZE_RESET;

        // Directed: reset window of 3, extremes, restart, duplicates,
        // size 0 and oversize, shrink and growth mid-sequence
        dir_rows = '{
            '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'sh0_FFFF_FFFE},
            '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'sh0_FFFF_FFFE},
            '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'sh1_0000_0000},
            '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'sh1_0000_0000},
            '{ROW_SAMPLE, 32'd5,         1'b1, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'hFFFF_FFF9, 1'b0, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'd5,         1'b0, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'd3,         1'b0, 1'b0, 33'sd0},
            '{ROW_WINDOW, 32'd0,         1'b0, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b1, 33'sh1_FFFF_FFFE},
            '{ROW_SAMPLE, 32'd12345,     1'b0, 1'b0, 33'sd0},
            '{ROW_WINDOW, 32'd127,       1'b0, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'd0,         1'b0, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'h5555_AAAA, 1'b0, 1'b0, 33'sd0},
            '{ROW_WINDOW, 32'd2,         1'b0, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'hAAAA_5555, 1'b0, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'd0,         1'b0, 1'b0, 33'sd0},
            '{ROW_WINDOW, 32'd4,         1'b0, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'd9,         1'b0, 1'b0, 33'sd0},
            '{ROW_SAMPLE, 32'd9,         1'b0, 1'b0, 33'sd0}
        };
        phase_sizes = '{7'd64, 7'd1, 7'd2, 7'd0, 7'd127, 7'd5, 7'd65, 7'd7,
                        7'd64, 7'd3, 7'd16, 7'd1};
        phase_sizes[N_PHASES-1] = WSIZE_W'($urandom_range(1, WIN_MAX));

        @(posedge rst_n);
        @(negedge clk);

        set_idle(IDLE_NONE);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WINDOW)
                write_window(dir_rows[i].value[WSIZE_W-1:0]);
            else
                send_word(dir_rows[i].value, dir_rows[i].restart,
                          dir_rows[i].has_typed, dir_rows[i].typed);
        end

        // Random phases: window size changes without restart, so most writes
        // also shrink or grow a live window
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_window(phase_sizes[ph]);
            set_idle(idle_mode_t'(ph % 4));
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ((ph == 1 && n == 40) || $urandom_range(63) == 0)
                    wait_drain();
                restart_odds = (eff_window() > 16) ? 199 : 29;
                send_word(pick_sample(), $urandom_range(restart_odds) == 0, 1'b0, '0);
            end
        end

        wait_drain();
        repeat (10) @(posedge clk);
        if (pending_medians.size() != 0)
            report_mismatch($sformatf("%0d medians never came out", pending_medians.size()));

        $display("Sent %0d words (%0d restarts) over %0d window size writes;",
                 words_sent, restarts_sent, window_writes);
        $display("%0d medians checked; window sizes 0 to 127, live windows shrunk and grown",
                 medians_checked);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
